// ===== rtl/core/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number test.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int FieldW  = 32;           // width of every coordinate field/register
	localparam int CoordW  = 32;           // bits of a field that carry the coordinate
	localparam int DiffW   = CoordW + 1;   // difference of two coordinates
	localparam int ProdW   = 2 * DiffW;    // product of two differences
	localparam int NumRegs = 2;
	localparam int CfgIdxW = $clog2(NumRegs);

	typedef logic signed [FieldW-1:0] field_t;
	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DiffW-1:0]  diff_t;
	typedef logic signed [ProdW-1:0]  prod_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POINT_X = 1'b0,
		REG_POINT_Y = 1'b1
	} reg_idx_t;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_SHORT = 1'b1
	} status_t;

	// Partial result of one edge test, carried between pipeline stages.
	typedef struct packed {
		logic  straddle;
		logic  dy_pos;
		prod_t lhs;
		prod_t rhs;
	} edge_t;

	function automatic coord_t sext(input field_t raw);
		return coord_t'(raw[CoordW-1:0]);
	endfunction

endpackage

// ===== rtl/core/pip_vtx_if.sv =====
// ----------------------------------------------------------------------------
// pip_vtx_if
// Vertex stream channel: one polygon vertex per transfer.
// ----------------------------------------------------------------------------
interface pip_vtx_if;
	import pip_pkg::*;

	logic   valid;
	logic   ready;
	field_t vertex_x;
	field_t vertex_y;
	logic   last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);

endinterface

// ===== rtl/core/pip_res_if.sv =====
// ----------------------------------------------------------------------------
// pip_res_if
// Result channel: one verdict per closed polygon.
// ----------------------------------------------------------------------------
interface pip_res_if;

	logic valid;
	logic ready;
	logic inside_res;
	logic status;

	modport source (output valid, output inside_res, output status, input ready);
	modport sink (input valid, input inside_res, input status, output ready);

endinterface

// ===== rtl/core/point_in_polygon_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Even-odd crossing-number point-in-polygon test over a streamed polygon.
//
//   channel   dir   payload                             transfer
//   vtx       in    vertex_x, vertex_y, last_vertex     valid & ready
//   res       out   inside_res, status                  valid & ready
//   cfg       in    cfg_index, cfg_data                 cfg_we
//
// One vertex per cycle unless a held result stalls the pipeline. A verdict
// reaches res through the input, multiplier and result registers. Each
// vertex tests its edge from the previous vertex; the closing vertex also
// tests the edge back to the first, so four multipliers work in parallel
// in the second stage. A held result only stalls a closing vertex behind
// it. Reset clears the test point, the vertex count and the parity.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pip_pkg::CfgIdxW-1:0] cfg_index,
	input  pip_pkg::field_t             cfg_data,
	pip_vtx_if.sink                     vtx,
	pip_res_if.source                   res
);
	import pip_pkg::*;

	// Edge from vertex j to vertex i, against the test point.
	function automatic edge_t edge_eval(input coord_t xi, input coord_t yi,
		input coord_t xj, input coord_t yj, input coord_t px, input coord_t py);
		edge_t e;
		diff_t dy;
		e.straddle = (yi > py) != (yj > py);
		e.dy_pos   = yj > yi;
		dy         = diff_t'(yj) - diff_t'(yi);
		e.lhs      = prod_t'(diff_t'(px) - diff_t'(xi)) * prod_t'(dy);
		e.rhs      = prod_t'(diff_t'(xj) - diff_t'(xi)) * prod_t'(diff_t'(py) - diff_t'(yi));
		return e;
	endfunction

	function automatic logic edge_hit(input edge_t e);
		return e.straddle && (e.dy_pos ? (e.lhs < e.rhs) : (e.rhs < e.lhs));
	endfunction

	// configuration and polygon state
	coord_t     point_x_q, point_y_q;
	coord_t     first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [1:0] seen_q;
	logic       parity_q;

	// stage 1
	logic   v_s1, edge_s1, last_s1, short_s1;
	coord_t x_s1, y_s1, px_s1, py_s1, fx_s1, fy_s1;

	// stage 2
	logic  v_s2, last_s2, short_s2;
	edge_t prev_edge_s2, close_edge_s2;
	edge_t prev_edge_d, close_edge_d;

	// result register
	logic    out_valid_q, inside_q;
	status_t status_q;

	logic   take_in, adv1, adv2, take2, out_block, hit_prev, hit_close, par_next;
	coord_t in_x, in_y;

	assign in_x      = sext(vtx.vertex_x);
	assign in_y      = sext(vtx.vertex_y);
	assign out_block = out_valid_q && !res.ready;
	assign adv2      = !(v_s2 && last_s2 && out_block);
	assign take2     = v_s2 && adv2;
	assign adv1      = !v_s2 || adv2;
	assign vtx.ready = !v_s1 || adv1;
	assign take_in   = vtx.valid && vtx.ready;

	always_comb begin
		prev_edge_d  = edge_eval(x_s1, y_s1, px_s1, py_s1, point_x_q, point_y_q);
		close_edge_d = edge_eval(fx_s1, fy_s1, x_s1, y_s1, point_x_q, point_y_q);
		if (!edge_s1) begin
			prev_edge_d.straddle = 1'b0;
		end
		if (!last_s1 || short_s1) begin
			close_edge_d.straddle = 1'b0;
		end
	end

	assign hit_prev  = edge_hit(prev_edge_s2);
	assign hit_close = edge_hit(close_edge_s2);
	assign par_next  = parity_q ^ hit_prev ^ hit_close;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q   <= '0;
			point_y_q   <= '0;
			seen_q      <= '0;
			parity_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_POINT_X: point_x_q <= sext(cfg_data);
					REG_POINT_Y: point_y_q <= sext(cfg_data);
					default: ;
				endcase
			end
			if (take_in) begin
				if (vtx.last_vertex) begin
					seen_q <= '0;
				end else if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
			if (vtx.ready) begin
				v_s1 <= take_in;
			end
			if (adv1) begin
				v_s2 <= v_s1;
			end
			if (take2) begin
				parity_q <= last_s2 ? 1'b0 : par_next;
			end
			if (take2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			if (seen_q == 2'd0) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
			end
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			x_s1     <= in_x;
			y_s1     <= in_y;
			px_s1    <= prev_x_q;
			py_s1    <= prev_y_q;
			// the first vertex closes against itself when it is also the last
			fx_s1    <= (seen_q == 2'd0) ? in_x : first_x_q;
			fy_s1    <= (seen_q == 2'd0) ? in_y : first_y_q;
			edge_s1  <= seen_q != 2'd0;
			last_s1  <= vtx.last_vertex;
			short_s1 <= seen_q < 2'd2;
		end
		if (adv1) begin
			prev_edge_s2  <= prev_edge_d;
			close_edge_s2 <= close_edge_d;
			last_s2       <= last_s1;
			short_s2      <= short_s1;
		end
		if (take2 && last_s2) begin
			inside_q <= short_s2 ? 1'b0 : par_next;
			status_q <= short_s2 ? STATUS_SHORT : STATUS_OK;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.inside_res = inside_q;
	assign res.status     = status_q;

endmodule
